// File: rtl/rlcs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rlcs_pkg;

    // Port field widths, fixed by the interface definition.
    localparam int REQ_TYPE_W = 2;
    localparam int VALUE_W    = 64;
    localparam int AMOUNT_W   = 32;
    localparam int ROW_W      = 32;
    localparam int STATUS_W   = 3;
    localparam int INDEX_W    = 10;
    localparam int TOTAL_W    = 32;
    localparam int RUNS_W     = 11;

    // Request codes.
    localparam logic [REQ_TYPE_W-1:0] REQ_APPEND = 2'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_READ   = 2'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_DROP   = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE     = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_DROP_OVER = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_ROW_OVF   = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_PROBE,
        ST_COMPARE,
        ST_FETCH,
        ST_APPLY,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

// File: rtl/rlcs_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Request channel: one word per append, read or drop.
interface rlcs_req_if;
    import rlcs_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [REQ_TYPE_W-1:0] req_type;
    logic [VALUE_W-1:0]    value;
    logic [AMOUNT_W-1:0]   amount;
    logic [ROW_W-1:0]      row;

    modport source (output valid, output req_type, output value, output amount,
                    output row, input ready);
    modport sink   (input valid, input req_type, input value, input amount,
                    input row, output ready);
endinterface

// Response channel: one word per request.
interface rlcs_rsp_if;
    import rlcs_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  read_value;
    logic [INDEX_W-1:0]  run_index;
    logic [TOTAL_W-1:0]  total_rows;
    logic [RUNS_W-1:0]   runs_in_use;

    modport source (output valid, output status, output read_value, output run_index,
                    output total_rows, output runs_in_use, input ready);
    modport sink   (input valid, input status, input read_value, input run_index,
                    input total_rows, input runs_in_use, output ready);
endinterface

`default_nettype wire

// File: rtl/run_length_column_store.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel | Direction | Word contents
// --------+-----------+------------------------------------------------------------
// req     | in        | req_type, value, amount, row
// rsp     | out       | status, read_value, run_index, total_rows, runs_in_use
//
// An append, a drop that needs no search, a request with an unknown code and every
// refused request go from ST_DECIDE to ST_FINISH, which loads the output register; the
// block takes no new word until that request's response word is loaded. A read or a
// partial drop binary-searches the run-end memory with one shared compare unit, each
// probe an address step, then a compare on the registered read data. Reset clears
// the run count and the row count at once; the run memories need no clearing pass.
// A stalled response word is held in the output register; the block takes the next
// request meanwhile and waits only if that one finishes before the old word is
// taken.

module run_length_column_store #(
    parameter int MAX_RUNS   = 1024,
    parameter int VALUE_BITS = 64,
    parameter int ROW_BITS   = 32
) (
    input  wire        clk,
    input  wire        rst_n,
    rlcs_req_if.sink   req,
    rlcs_rsp_if.source rsp
);
    import rlcs_pkg::*;

    localparam int IDX_BITS = $clog2(MAX_RUNS);
    localparam int CNT_BITS = $clog2(MAX_RUNS + 1);
    // Wide enough for row counts, 32-bit amounts and one carry bit.
    localparam int WB = ((ROW_BITS > AMOUNT_W) ? ROW_BITS : AMOUNT_W) + 1;
    localparam logic [WB-1:0] ROW_LIMIT = {{(WB - ROW_BITS){1'b0}}, {ROW_BITS{1'b1}}};
    localparam logic [CNT_BITS-1:0] RUNS_FULL = CNT_BITS'(MAX_RUNS);

    // Run memories: value and last row of each run.
    logic [VALUE_BITS-1:0] run_value    [MAX_RUNS];
    logic [ROW_BITS-1:0]   run_last_row [MAX_RUNS];

    state_t state_reg, state_next;

    // Column state. The last run's value is mirrored so an append never reads memory.
    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic [ROW_BITS-1:0]   total_reg, total_next;
    logic [VALUE_BITS-1:0] last_value_reg, last_value_next;

    // Latched request.
    logic [REQ_TYPE_W-1:0] type_reg, type_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [AMOUNT_W-1:0]   amount_reg, amount_next;
    logic [ROW_W-1:0]      row_reg, row_next;

    // Search state.
    logic [CNT_BITS-1:0]   lo_reg, lo_next;
    logic [CNT_BITS-1:0]   hi_reg, hi_next;
    logic [ROW_BITS-1:0]   target_reg, target_next;
    logic [CNT_BITS-1:0]   mid;

    // Pending result.
    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic [VALUE_BITS-1:0] res_value_reg, res_value_next;
    logic [IDX_BITS-1:0]   res_index_reg, res_index_next;

    // Output register.
    logic                  out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]   out_status_reg, out_status_next;
    logic [VALUE_W-1:0]    out_value_reg, out_value_next;
    logic [INDEX_W-1:0]    out_index_reg, out_index_next;
    logic [TOTAL_W-1:0]    out_total_reg, out_total_next;
    logic [RUNS_W-1:0]     out_runs_reg, out_runs_next;

    // Memory ports.
    logic [IDX_BITS-1:0]   rd_addr;
    logic [ROW_BITS-1:0]   rd_last_reg;
    logic [VALUE_BITS-1:0] rd_value_reg;
    logic                  wr_last_en, wr_value_en;
    logic [IDX_BITS-1:0]   wr_addr;
    logic [ROW_BITS-1:0]   wr_last_data;

    // Wide arithmetic views.
    logic [WB-1:0] total_w, amount_w, row_w, sum_w, remain_w;

    assign mid      = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign rd_addr  = IDX_BITS'((state_reg == ST_FETCH) ? lo_reg : mid);
    assign total_w  = WB'(total_reg);
    assign amount_w = WB'(amount_reg);
    assign row_w    = WB'(row_reg);
    assign sum_w    = total_w + amount_w;
    assign remain_w = total_w - amount_w;

    assign req.ready       = (state_reg == ST_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.read_value  = out_value_reg;
    assign rsp.run_index   = out_index_reg;
    assign rsp.total_rows  = out_total_reg;
    assign rsp.runs_in_use = out_runs_reg;

    always_ff @(posedge clk)
    begin
        rd_last_reg  <= run_last_row[rd_addr];
        rd_value_reg <= run_value[rd_addr];
        if (wr_last_en)
        begin
            run_last_row[wr_addr] <= wr_last_data;
        end
        if (wr_value_en)
        begin
            run_value[wr_addr] <= val_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_value_reg <= last_value_next;
        type_reg       <= type_next;
        val_reg        <= val_next;
        amount_reg     <= amount_next;
        row_reg        <= row_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        target_reg     <= target_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        res_index_reg  <= res_index_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
        out_index_reg  <= out_index_next;
        out_total_reg  <= out_total_next;
        out_runs_reg   <= out_runs_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        total_next      = total_reg;
        last_value_next = last_value_reg;
        type_next       = type_reg;
        val_next        = val_reg;
        amount_next     = amount_reg;
        row_next        = row_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        target_next     = target_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        res_index_next  = res_index_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_index_next  = out_index_reg;
        out_total_next  = out_total_reg;
        out_runs_next   = out_runs_reg;
        wr_last_en      = 1'b0;
        wr_value_en     = 1'b0;
        wr_addr         = IDX_BITS'(count_reg);
        wr_last_data    = ROW_BITS'(sum_w - WB'(1));

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    type_next   = req.req_type;
                    val_next    = VALUE_BITS'(req.value);
                    amount_next = req.amount;
                    row_next    = req.row;
                    state_next  = ST_DECIDE;
                end
            end

            ST_DECIDE:
            begin
                // Most requests finish here; reads and partial drops start a search.
                res_status_next = STATUS_OK;
                res_value_next  = '0;
                res_index_next  = '0;
                lo_next         = '0;
                hi_next         = count_reg;
                state_next      = ST_FINISH;
                case (type_reg)
                    REQ_APPEND:
                    begin
                        if (amount_reg == '0)
                        begin
                            res_status_next = STATUS_OK;
                        end
                        else if (amount_w > ROW_LIMIT - total_w)
                        begin
                            res_status_next = STATUS_ROW_OVF;
                        end
                        else if (count_reg != '0 && last_value_reg == val_reg)
                        begin
                            // Same value as the last run: stretch it.
                            wr_last_en = 1'b1;
                            wr_addr    = IDX_BITS'(count_reg - CNT_BITS'(1));
                            total_next = ROW_BITS'(sum_w);
                        end
                        else if (count_reg >= RUNS_FULL)
                        begin
                            res_status_next = STATUS_FULL;
                        end
                        else
                        begin
                            wr_last_en      = 1'b1;
                            wr_value_en     = 1'b1;
                            count_next      = count_reg + CNT_BITS'(1);
                            total_next      = ROW_BITS'(sum_w);
                            last_value_next = val_reg;
                        end
                    end
                    REQ_READ:
                    begin
                        if (row_w >= total_w)
                        begin
                            res_status_next = STATUS_RANGE;
                        end
                        else
                        begin
                            target_next = ROW_BITS'(row_reg);
                            state_next  = ST_PROBE;
                        end
                    end
                    REQ_DROP:
                    begin
                        if (amount_reg == '0)
                        begin
                            res_status_next = STATUS_OK;
                        end
                        else if (amount_w > total_w)
                        begin
                            res_status_next = STATUS_DROP_OVER;
                        end
                        else if (amount_w == total_w)
                        begin
                            count_next = '0;
                            total_next = '0;
                        end
                        else
                        begin
                            // Search for the run that will hold the new last row.
                            target_next = ROW_BITS'(remain_w - WB'(1));
                            state_next  = ST_PROBE;
                        end
                    end
                    default:
                    begin
                        res_status_next = STATUS_OK;
                    end
                endcase
            end

            ST_PROBE:
            begin
                // The read of the run end at mid is issued in this cycle.
                state_next = (lo_reg < hi_reg) ? ST_COMPARE : ST_FETCH;
            end

            ST_COMPARE:
            begin
                if (rd_last_reg < target_reg)
                begin
                    lo_next = mid + CNT_BITS'(1);
                end
                else
                begin
                    hi_next = mid;
                end
                state_next = ST_PROBE;
            end

            ST_FETCH:
            begin
                // The covering run is lo; its value arrives next cycle.
                state_next = ST_APPLY;
            end

            ST_APPLY:
            begin
                if (type_reg == REQ_READ)
                begin
                    res_value_next = rd_value_reg;
                    res_index_next = IDX_BITS'(lo_reg);
                end
                else
                begin
                    wr_last_en      = 1'b1;
                    wr_addr         = IDX_BITS'(lo_reg);
                    wr_last_data    = target_reg;
                    count_next      = lo_reg + CNT_BITS'(1);
                    total_next      = target_reg + ROW_BITS'(1);
                    last_value_next = rd_value_reg;
                end
                state_next = ST_FINISH;
            end

            ST_FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_value_next  = VALUE_W'(res_value_reg);
                    out_index_next  = INDEX_W'(res_index_reg);
                    out_total_next  = TOTAL_W'(total_reg);
                    out_runs_next   = RUNS_W'(count_reg);
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // An empty run table and a zero row count always go together.
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) == (total_reg == '0))
        else $error("run count and row count disagree on emptiness");

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= RUNS_FULL)
        else $error("run count beyond table size");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PROBE || state_reg == ST_COMPARE) |-> lo_reg <= hi_reg)
        else $error("search bounds crossed");

    // A search only starts for a row that is held, so it always lands on a run.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FETCH |-> lo_reg < count_reg)
        else $error("search ended past the last run");

    assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request taken while a request is in progress");

endmodule

`default_nettype wire
